/* rtl/point_segment_distance_unit_core_defines.svh */
// Assertion macros for the point-to-segment distance unit.
// Used by the top level only; every macro expects aclk and aresetn in scope.
`ifndef POINT_SEGMENT_DISTANCE_UNIT_CORE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/psd_pkg.sv */
// Shared widths, register indexes and pipeline tag types of the distance unit.
// No dependencies; used by the top level of the block.
`timescale 1ns / 1ps

package psd_pkg;

    localparam int COORD_W  = 24;
    localparam int TOL_W    = 12;
    localparam int SIDE_W   = 52;
    localparam int DIST_W   = 25;
    localparam int DIFF_W   = COORD_W + 1;      // coordinate differences
    localparam int SQ_W     = 2 * COORD_W;      // one squared difference
    localparam int RAD_W    = 2 * DIST_W;       // radicands and divider words
    localparam int DIVD_W   = 2 * RAD_W;        // squared side value
    localparam int SUM_W    = DIST_W + 1;
    localparam int IDX_W    = 3;
    localparam int LANES    = 4;

    localparam logic [IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_END_X   = 3'd2;
    localparam logic [IDX_W-1:0] REG_END_Y   = 3'd3;
    localparam logic [IDX_W-1:0] REG_TOL     = 3'd4;

    // Lanes of the square-root chain.
    localparam int LANE_QUOT = 0;
    localparam int LANE_D0   = 1;
    localparam int LANE_D1   = 2;
    localparam int LANE_LEN  = 3;

    typedef struct packed {
        logic signed [SIDE_W-1:0] side;
        logic                     degen;
        logic [TOL_W-1:0]         tol;
    } sqrt_tag_t;

    typedef struct packed {
        sqrt_tag_t        base;
        logic [RAD_W-1:0] q0;
        logic [RAD_W-1:0] q1;
    } div_tag_t;

endpackage

/* rtl/psd_div_cell.sv */
// One step of the restoring divider chain: one quotient bit per cell.
// Depends on nothing; the tag is carried along untouched.
`timescale 1ns / 1ps

module psd_div_cell #(
    parameter int W     = 50,
    parameter int TAG_W = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [W-1:0]     in_rem,
    input  logic [W-1:0]     in_word,
    input  logic [W-1:0]     in_divisor,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [W-1:0]     out_rem,
    output logic [W-1:0]     out_word,
    output logic [W-1:0]     out_divisor,
    output logic [TAG_W-1:0] out_tag
);

    logic             valid_reg;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     word_reg, word_next;
    logic [W-1:0]     divisor_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             fits;

    // The word holds the remaining dividend bits at the top and collects
    // quotient bits at the bottom.
    always_comb begin
        shifted   = {in_rem, in_word[W-1]};
        diff      = shifted - {1'b0, in_divisor};
        fits      = shifted >= {1'b0, in_divisor};
        rem_next  = fits ? diff[W-1:0] : shifted[W-1:0];
        word_next = {in_word[W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg     <= rem_next;
            word_reg    <= word_next;
            divisor_reg <= in_divisor;
            tag_reg     <= in_tag;
        end
    end

    assign out_valid   = valid_reg;
    assign out_rem     = rem_reg;
    assign out_word    = word_reg;
    assign out_divisor = divisor_reg;
    assign out_tag     = tag_reg;

endmodule

/* rtl/psd_sqrt_cell.sv */
// One step of the digit-by-digit integer square root, for several lanes.
// Depends on nothing; the tag is carried along untouched.
`timescale 1ns / 1ps

module psd_sqrt_cell #(
    parameter int K     = 25,
    parameter int LANES = 4,
    parameter int TAG_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][2*K-1:0]   in_rad,
    input  logic [LANES-1:0][K:0]       in_rem,
    input  logic [LANES-1:0][K-1:0]     in_root,
    input  logic [TAG_W-1:0]            in_tag,
    output logic                        out_valid,
    output logic [LANES-1:0][2*K-1:0]   out_rad,
    output logic [LANES-1:0][K:0]       out_rem,
    output logic [LANES-1:0][K-1:0]     out_root,
    output logic [TAG_W-1:0]            out_tag
);

    logic                      valid_reg;
    logic [LANES-1:0][2*K-1:0] rad_reg, rad_next;
    logic [LANES-1:0][K:0]     rem_reg, rem_next;
    logic [LANES-1:0][K-1:0]   root_reg, root_next;
    logic [TAG_W-1:0]          tag_reg;
    logic [LANES-1:0][K+1:0]   part;
    logic [LANES-1:0][K+1:0]   trial;
    logic [LANES-1:0][K+1:0]   left;
    logic [LANES-1:0]          fits;

    // The remainder never exceeds twice the partial root, so its top bit
    // is clear whenever it is shifted in.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            part[l]      = {in_rem[l][K-1:0], in_rad[l][2*K-1:2*K-2]};
            trial[l]     = {in_root[l], 2'b01};
            fits[l]      = part[l] >= trial[l];
            left[l]      = part[l] - trial[l];
            rem_next[l]  = fits[l] ? left[l][K:0] : part[l][K:0];
            root_next[l] = {in_root[l][K-2:0], fits[l]};
            rad_next[l]  = {in_rad[l][2*K-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            tag_reg  <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_tag   = tag_reg;

endmodule

/* rtl/point_segment_distance_unit_core.sv */
// Point-to-segment distance unit. Channels: query items in on s_valid/s_ready
// (s_query_x, s_query_y, signed Q12.12); one result item per query out on
// m_valid/m_ready (side value, perpendicular distance, on-segment flag and
// degenerate flag). Segment endpoints and tolerance are written through the
// cfg_valid/cfg_ready port (always ready); the user must write them only while
// the unit is idle; the block does not enforce this. Five front stages
// (differences, products, sums, partial products, split square of the side
// value), 50 divider cells producing one quotient bit each, 25 square-root
// cells producing one root bit each on four lanes, and the output register
// take one item per cycle unless the chain freezes. When the receiver stalls,
// the output register holds its item and the pipeline keeps moving as long as
// its last stage is empty; only when a finished item meets a full output
// register does the whole chain freeze and s_ready fall. Synchronous reset
// empties every stage and sets the endpoints to zero and the tolerance to one.
// Depends on psd_pkg, psd_div_cell, psd_sqrt_cell and the defines header.
`timescale 1ns / 1ps
`include "point_segment_distance_unit_core_defines.svh"

module point_segment_distance_unit_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [psd_pkg::IDX_W-1:0]            cfg_index,
    input  logic [psd_pkg::COORD_W-1:0]          cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [psd_pkg::COORD_W-1:0]   s_query_x,
    input  logic signed [psd_pkg::COORD_W-1:0]   s_query_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [psd_pkg::SIDE_W-1:0]    m_side_value,
    output logic [psd_pkg::DIST_W-1:0]           m_line_distance,
    output logic                                 m_on_segment,
    output logic                                 m_degenerate
);

    localparam int CW   = psd_pkg::COORD_W;
    localparam int DW   = psd_pkg::DIFF_W;
    localparam int PW   = 2 * DW;
    localparam int SQW  = psd_pkg::SQ_W;
    localparam int RW   = psd_pkg::RAD_W;
    localparam int K    = psd_pkg::DIST_W;
    localparam int HW   = RW / 2;
    localparam int SW   = psd_pkg::SIDE_W;
    localparam int DIVN = RW;
    localparam int SQN  = K;
    localparam int DTW  = $bits(psd_pkg::div_tag_t);
    localparam int STW  = $bits(psd_pkg::sqrt_tag_t);

    // Configuration registers.
    logic signed [CW-1:0]            sx_reg, sy_reg, ex_reg, ey_reg;
    logic [psd_pkg::TOL_W-1:0]       tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg  <= '0;
            sy_reg  <= '0;
            ex_reg  <= '0;
            ey_reg  <= '0;
            tol_reg <= psd_pkg::TOL_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                psd_pkg::REG_START_X: sx_reg  <= cfg_data;
                psd_pkg::REG_START_Y: sy_reg  <= cfg_data;
                psd_pkg::REG_END_X:   ex_reg  <= cfg_data;
                psd_pkg::REG_END_Y:   ey_reg  <= cfg_data;
                psd_pkg::REG_TOL:     tol_reg <= cfg_data[psd_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic en;
    logic tail_valid;
    logic m_valid_reg;

    // The chain advances unless a finished item would land on a held result.
    assign en      = !m_valid_reg || m_ready || !tail_valid;
    assign s_ready = en;

    // Stage 1: coordinate differences.
    logic                      v1_reg;
    logic signed [DW-1:0]      a1_reg, b1_reg, dx0_reg, dy0_reg, dx1_reg, dy1_reg;
    logic [psd_pkg::TOL_W-1:0] tol1_reg;
    logic                      degen1_reg;

    // Stage 2: products.
    logic                      v2_reg;
    logic signed [PW-1:0]      pa2_reg, pb2_reg;
    logic [SQW-1:0]            sqa2_reg, sqb2_reg, sx02_reg, sy02_reg, sx12_reg, sy12_reg;
    logic [psd_pkg::TOL_W-1:0] tol2_reg;
    logic                      degen2_reg;
    logic signed [PW-1:0]      pa_next, pb_next, sqa_next, sqb_next;
    logic signed [PW-1:0]      sx0_next, sy0_next, sx1_next, sy1_next;

    // Stage 3: sums.
    logic                      v3_reg;
    logic signed [SW-1:0]      side3_reg, side_next, mag_next;
    logic [RW-1:0]             s3_reg, n3_reg, q03_reg, q13_reg;
    logic [psd_pkg::TOL_W-1:0] tol3_reg;
    logic                      degen3_reg;

    // Stage 4: partial products of the squared side value.
    logic                      v4_reg;
    logic [RW-1:0]             hh4_reg, hl4_reg, ll4_reg;
    logic [RW-1:0]             n4_reg;
    logic [HW-1:0]             sh, sl;
    psd_pkg::div_tag_t         tag4_reg;

    // Stage 5: the squared side value, split for the divider.
    logic                      v5_reg;
    logic [psd_pkg::DIVD_W-1:0] s2_next;
    logic [RW-1:0]             rem5_reg, word5_reg, n5_reg;
    psd_pkg::div_tag_t         tag5_reg;

    always_comb begin
        pa_next  = a1_reg * dx0_reg;
        pb_next  = b1_reg * dy0_reg;
        sqa_next = a1_reg * a1_reg;
        sqb_next = b1_reg * b1_reg;
        sx0_next = dx0_reg * dx0_reg;
        sy0_next = dy0_reg * dy0_reg;
        sx1_next = dx1_reg * dx1_reg;
        sy1_next = dy1_reg * dy1_reg;
        side_next = SW'(pa2_reg) + SW'(pb2_reg);
        mag_next  = side_next[SW-1] ? -side_next : side_next;
        sh = s3_reg[RW-1:HW];
        sl = s3_reg[HW-1:0];
        s2_next = (psd_pkg::DIVD_W'(hh4_reg) << RW)
                + (psd_pkg::DIVD_W'(hl4_reg) << (HW + 1))
                + psd_pkg::DIVD_W'(ll4_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg     <= DW'(ey_reg) - DW'(sy_reg);
            b1_reg     <= DW'(sx_reg) - DW'(ex_reg);
            dx0_reg    <= DW'(s_query_x) - DW'(sx_reg);
            dy0_reg    <= DW'(s_query_y) - DW'(sy_reg);
            dx1_reg    <= DW'(s_query_x) - DW'(ex_reg);
            dy1_reg    <= DW'(s_query_y) - DW'(ey_reg);
            tol1_reg   <= tol_reg;
            degen1_reg <= (sx_reg == ex_reg) && (sy_reg == ey_reg);

            pa2_reg    <= pa_next;
            pb2_reg    <= pb_next;
            sqa2_reg   <= sqa_next[SQW-1:0];
            sqb2_reg   <= sqb_next[SQW-1:0];
            sx02_reg   <= sx0_next[SQW-1:0];
            sy02_reg   <= sy0_next[SQW-1:0];
            sx12_reg   <= sx1_next[SQW-1:0];
            sy12_reg   <= sy1_next[SQW-1:0];
            tol2_reg   <= tol1_reg;
            degen2_reg <= degen1_reg;

            side3_reg  <= side_next;
            s3_reg     <= mag_next[RW-1:0];
            n3_reg     <= RW'(sqa2_reg) + RW'(sqb2_reg);
            q03_reg    <= RW'(sx02_reg) + RW'(sy02_reg);
            q13_reg    <= RW'(sx12_reg) + RW'(sy12_reg);
            tol3_reg   <= tol2_reg;
            degen3_reg <= degen2_reg;

            hh4_reg             <= RW'(sh) * RW'(sh);
            hl4_reg             <= RW'(sh) * RW'(sl);
            ll4_reg             <= RW'(sl) * RW'(sl);
            n4_reg              <= n3_reg;
            tag4_reg.base.side  <= side3_reg;
            tag4_reg.base.degen <= degen3_reg;
            tag4_reg.base.tol   <= tol3_reg;
            tag4_reg.q0         <= q03_reg;
            tag4_reg.q1         <= q13_reg;

            // The quotient stays below the squared point distance, so the
            // upper half is already smaller than the divisor.
            rem5_reg  <= s2_next[psd_pkg::DIVD_W-1:RW];
            word5_reg <= s2_next[RW-1:0];
            n5_reg    <= n4_reg;
            tag5_reg  <= tag4_reg;
        end
    end

    // Divider chain: squared side value over A*A+B*B.
    logic           dv  [0:DIVN];
    logic [RW-1:0]  drem[0:DIVN];
    logic [RW-1:0]  dwrd[0:DIVN];
    logic [RW-1:0]  ddiv[0:DIVN];
    logic [DTW-1:0] dtag[0:DIVN];

    assign dv[0]   = v5_reg;
    assign drem[0] = rem5_reg;
    assign dwrd[0] = word5_reg;
    assign ddiv[0] = n5_reg;
    assign dtag[0] = tag5_reg;

    for (genvar i = 0; i < DIVN; i++) begin : g_div
        psd_div_cell #(
            .W     (RW),
            .TAG_W (DTW)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (en),
            .in_valid    (dv[i]),
            .in_rem      (drem[i]),
            .in_word     (dwrd[i]),
            .in_divisor  (ddiv[i]),
            .in_tag      (dtag[i]),
            .out_valid   (dv[i+1]),
            .out_rem     (drem[i+1]),
            .out_word    (dwrd[i+1]),
            .out_divisor (ddiv[i+1]),
            .out_tag     (dtag[i+1])
        );
    end

    // Square-root chain over quotient, both endpoint distances and length.
    psd_pkg::div_tag_t          dtail;
    logic                       qv   [0:SQN];
    logic [psd_pkg::LANES-1:0][2*K-1:0] qrad [0:SQN];
    logic [psd_pkg::LANES-1:0][K:0]     qrem [0:SQN];
    logic [psd_pkg::LANES-1:0][K-1:0]   qroot[0:SQN];
    logic [STW-1:0]             qtag [0:SQN];

    always_comb begin
        dtail = psd_pkg::div_tag_t'(dtag[DIVN]);
        qrad[0]                   = '0;
        qrad[0][psd_pkg::LANE_QUOT] = dwrd[DIVN];
        qrad[0][psd_pkg::LANE_D0]   = dtail.q0;
        qrad[0][psd_pkg::LANE_D1]   = dtail.q1;
        qrad[0][psd_pkg::LANE_LEN]  = ddiv[DIVN];
    end

    assign qv[0]    = dv[DIVN];
    assign qrem[0]  = '0;
    assign qroot[0] = '0;
    assign qtag[0]  = dtail.base;

    for (genvar i = 0; i < SQN; i++) begin : g_sqrt
        psd_sqrt_cell #(
            .K     (K),
            .LANES (psd_pkg::LANES),
            .TAG_W (STW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (qv[i]),
            .in_rad    (qrad[i]),
            .in_rem    (qrem[i]),
            .in_root   (qroot[i]),
            .in_tag    (qtag[i]),
            .out_valid (qv[i+1]),
            .out_rad   (qrad[i+1]),
            .out_rem   (qrem[i+1]),
            .out_root  (qroot[i+1]),
            .out_tag   (qtag[i+1])
        );
    end

    // Output stage.
    psd_pkg::sqrt_tag_t        qtail;
    logic [psd_pkg::SUM_W-1:0] dsum, dlen, ddiff;
    logic                      on_seg;
    logic signed [SW-1:0]      side_reg;
    logic [K-1:0]              dist_reg;
    logic                      on_seg_reg;
    logic                      degen_reg;

    assign tail_valid = qv[SQN];

    always_comb begin
        qtail  = psd_pkg::sqrt_tag_t'(qtag[SQN]);
        dsum   = psd_pkg::SUM_W'(qroot[SQN][psd_pkg::LANE_D0])
               + psd_pkg::SUM_W'(qroot[SQN][psd_pkg::LANE_D1]);
        dlen   = psd_pkg::SUM_W'(qroot[SQN][psd_pkg::LANE_LEN]);
        ddiff  = (dsum >= dlen) ? dsum - dlen : dlen - dsum;
        on_seg = ddiff <= psd_pkg::SUM_W'(qtail.tol);
    end

    // A held item stays until taken, even while bubbles move up behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en && tail_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && tail_valid) begin
            side_reg   <= qtail.side;
            dist_reg   <= qtail.degen ? '0 : qroot[SQN][psd_pkg::LANE_QUOT];
            on_seg_reg <= on_seg;
            degen_reg  <= qtail.degen;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_side_value    = side_reg;
    assign m_line_distance = dist_reg;
    assign m_on_segment    = on_seg_reg;
    assign m_degenerate    = degen_reg;

    // A degenerate segment gives a zero side value and zero distance.
    `PSD_ASSERT_NOW(a_degen_zero, m_valid && m_degenerate, (m_line_distance == '0) && (m_side_value == '0), "degenerate item with non-zero distance or side value")
    // Input is only refused while a held result blocks a finished item.
    `PSD_ASSERT_NOW(a_stall_cause, !s_ready, m_valid && !m_ready && tail_valid, "input refused without an output stall")
    // A held result is not lost while the receiver stalls.
    `PSD_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid && $stable(m_side_value), "stalled item dropped or changed")

endmodule
